// ===== sv/vfs_pkg.sv =====
// ----------------------------------------------------------------------------
// vfs_pkg
// Shared constants, codes and element conversion helpers for the versioned
// FIFO snapshot block.
// ----------------------------------------------------------------------------
package vfs_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int VERSION_DEPTH = 128;
    localparam int ELEMENT_WIDTH = 32;

    // Fixed port widths
    localparam int ACT_W  = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 3;
    localparam int VER_W  = 8;

    // Derived widths
    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);      // element store address
    localparam int IDX_W   = $clog2(QUEUE_DEPTH + 1);  // head/tail/count, holds QUEUE_DEPTH
    localparam int VADDR_W = $clog2(VERSION_DEPTH);    // snapshot table address
    localparam int CNT_W   = $clog2(VERSION_DEPTH + 1);
    localparam int SNAP_W  = 2 * IDX_W;                // {head, count}
    localparam int CMP_W   = (CNT_W > VER_W) ? CNT_W : VER_W;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_ENQ    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REPLAY = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_VER   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

    typedef logic [ELEMENT_WIDTH-1:0] elem_t;

    // Keep the low element bits of the zero-extended request value
    function automatic elem_t value_to_elem(input logic [DATA_W-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[ELEMENT_WIDTH-1:0];
    endfunction

    // Sign-extend an element and keep the data width
    function automatic logic [DATA_W-1:0] elem_to_data(input elem_t e);
        logic [63:0] wide;
        wide = 64'(signed'(e));
        return wide[DATA_W-1:0];
    endfunction

endpackage

// ===== sv/versioned_fifo_snapshot_top.sv =====
// ----------------------------------------------------------------------------
// versioned_fifo_snapshot_top
// Non-wrapping FIFO with a version table of (head, count) snapshots and
// replay of any recorded version.
// ----------------------------------------------------------------------------
// Timing: enqueue requests and all error results (overflow, underflow, bad
// version) go straight into the output register. A dequeue passes through
// ST_DEQ to wait for the registered read data of the element store. A
// replay reads the snapshot table, fetches the first element in ST_SNAP, and
// then delivers one element per cycle in ST_REP while m_ready stays high; an
// empty snapshot ends in ST_SNAP with STAT_EMPTY. A new request is taken once
// the previous one has issued its final result and the output register is
// free or being drained in the same cycle. Both memories power up undefined
// and need no clearing pass; only recorded entries are ever read.
// ----------------------------------------------------------------------------
module versioned_fifo_snapshot_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [vfs_pkg::ACT_W-1:0]   s_action,
    input  logic signed [vfs_pkg::DATA_W-1:0] s_value,
    input  logic [vfs_pkg::VER_W-1:0]   s_version_number,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [vfs_pkg::DATA_W-1:0] m_data,
    output logic [vfs_pkg::STAT_W-1:0]  m_status,
    output logic                        m_last,
    output logic [vfs_pkg::VER_W-1:0]   m_versions_recorded
);
    import vfs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DEQ  = 2'd1;
    localparam logic [1:0] ST_SNAP = 2'd2;
    localparam logic [1:0] ST_REP  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic [IDX_W-1:0] rep_left_reg, rep_left_next;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic              m_last_reg, m_last_next;
    logic [VER_W-1:0]  m_ver_reg, m_ver_next;

    // memory ports
    logic               e_we, e_re;
    logic [ADDR_W-1:0]  e_waddr, e_raddr;
    elem_t              e_wdata, e_rdata;
    logic               t_we, t_re;
    logic [VADDR_W-1:0] t_waddr, t_raddr;
    logic [SNAP_W-1:0]  t_wdata, t_rdata;

    logic out_free, accept;
    logic [IDX_W-1:0] snap_head, snap_cnt;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign snap_head = t_rdata[SNAP_W-1:IDX_W];
    assign snap_cnt  = t_rdata[IDX_W-1:0];

    vfs_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(QUEUE_DEPTH)) u_elem_ram (
        .aclk  (aclk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    vfs_ram #(.WIDTH(SNAP_W), .DEPTH(VERSION_DEPTH)) u_snap_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        rep_idx_next  = rep_idx_reg;
        rep_left_next = rep_left_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        m_ver_next    = m_ver_reg;

        e_we    = 1'b0;
        e_waddr = tail_reg[ADDR_W-1:0];
        e_wdata = value_to_elem(s_value);
        e_re    = 1'b0;
        e_raddr = head_reg[ADDR_W-1:0];
        t_we    = 1'b0;
        t_waddr = count_reg[VADDR_W-1:0];
        t_wdata = '0;
        t_re    = 1'b0;
        t_raddr = VADDR_W'(s_version_number - 1'b1);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_data_next   = '0;
                    m_last_next   = 1'b1;
                    m_ver_next    = VER_W'(count_reg);
                    case (s_action)
                        ACT_ENQ: begin
                            m_valid_next = 1'b1;
                            if (tail_reg == IDX_W'(QUEUE_DEPTH)) begin
                                m_status_next = STAT_OVERFLOW;
                            end else begin
                                e_we      = 1'b1;
                                tail_next = tail_reg + 1'b1;
                                if (count_reg < CNT_W'(VERSION_DEPTH)) begin
                                    t_we       = 1'b1;
                                    t_wdata    = {head_reg, IDX_W'(tail_reg + 1'b1 - head_reg)};
                                    count_next = count_reg + 1'b1;
                                end
                                m_status_next = STAT_OK;
                                m_ver_next    = VER_W'(count_next);
                            end
                        end
                        ACT_DEQ: begin
                            if (head_reg >= tail_reg) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_UNDERFLOW;
                            end else begin
                                e_re      = 1'b1;
                                head_next = head_reg + 1'b1;
                                if (count_reg < CNT_W'(VERSION_DEPTH)) begin
                                    t_we       = 1'b1;
                                    t_wdata    = {IDX_W'(head_reg + 1'b1),
                                                  IDX_W'(tail_reg - head_reg - 1'b1)};
                                    count_next = count_reg + 1'b1;
                                end
                                state_next = ST_DEQ;
                            end
                        end
                        ACT_REPLAY: begin
                            if (s_version_number == '0 ||
                                CMP_W'(s_version_number) > CMP_W'(count_reg)) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_BAD_VER;
                            end else begin
                                t_re       = 1'b1;
                                state_next = ST_SNAP;
                            end
                        end
                        default: begin
                            // unused action: drop the request
                        end
                    endcase
                end
            end
            ST_DEQ: begin
                m_valid_next  = 1'b1;
                m_data_next   = elem_to_data(e_rdata);
                m_status_next = STAT_OK;
                m_last_next   = 1'b1;
                m_ver_next    = VER_W'(count_reg);
                state_next    = ST_IDLE;
            end
            ST_SNAP: begin
                if (snap_cnt == '0) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = '0;
                    m_status_next = STAT_EMPTY;
                    m_last_next   = 1'b1;
                    m_ver_next    = VER_W'(count_reg);
                    state_next    = ST_IDLE;
                end else begin
                    e_re          = 1'b1;
                    e_raddr       = snap_head[ADDR_W-1:0];
                    rep_idx_next  = snap_head + 1'b1;
                    rep_left_next = snap_cnt;
                    state_next    = ST_REP;
                end
            end
            ST_REP: begin
                // read data holds until the output slot takes it
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = elem_to_data(e_rdata);
                    m_status_next = STAT_OK;
                    m_last_next   = (rep_left_reg == IDX_W'(1));
                    m_ver_next    = VER_W'(count_reg);
                    rep_left_next = rep_left_reg - 1'b1;
                    if (rep_left_reg == IDX_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        e_re         = 1'b1;
                        e_raddr      = rep_idx_reg[ADDR_W-1:0];
                        rep_idx_next = rep_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            rep_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            rep_left_reg <= rep_left_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_idx_reg  <= rep_idx_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        m_ver_reg    <= m_ver_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_data              = m_data_reg;
    assign m_status            = m_status_reg;
    assign m_last              = m_last_reg;
    assign m_versions_recorded = m_ver_reg;

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg && tail_reg <= IDX_W'(QUEUE_DEPTH))
        else $error("head/tail index order broken");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(VERSION_DEPTH))
        else $error("snapshot count beyond table depth");

    a_rep_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REP |-> rep_left_reg != '0)
        else $error("replay running with no elements left");

    a_enq_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action == ACT_ENQ && tail_reg != IDX_W'(QUEUE_DEPTH))
        |=> tail_reg == $past(tail_reg) + 1'b1)
        else $error("enqueue did not advance tail");

endmodule

// ===== sv/vfs_ram.sv =====
// ----------------------------------------------------------------------------
// vfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
